[rtl/core/lddc_pkg.sv]
// Package with shared constants for the digit dominance counter.
`timescale 1ns / 1ps
package lddc_pkg;
    localparam int VALUE_BITS = 64;
    localparam int MAX_DIGITS = 64;
    localparam int DIGIT_BITS = 16;
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BASE  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LIMIT = 1'b1;
    localparam logic [DIGIT_BITS-1:0] BASE_RESET = 16'd2;
endpackage

[rtl/core/lddc_ram.sv]
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`timescale 1ns / 1ps
module lddc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/core/lddc_divider.sv]
// Restoring divider, one quotient bit per cycle, value by 16-bit base.
`timescale 1ns / 1ps
module lddc_divider #(
    parameter int VALUE_BITS = lddc_pkg::VALUE_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [VALUE_BITS-1:0]           i_dividend,
    input  logic [lddc_pkg::DIGIT_BITS-1:0] i_divisor,
    output logic                            o_done,
    output logic [VALUE_BITS-1:0]           o_quotient,
    output logic [lddc_pkg::DIGIT_BITS-1:0] o_remainder
);
    localparam int CW = $clog2(VALUE_BITS + 1);
    logic [VALUE_BITS-1:0]           r_q;
    logic [lddc_pkg::DIGIT_BITS:0]   r_rem;
    logic [lddc_pkg::DIGIT_BITS-1:0] r_div;
    logic [CW-1:0]                   r_cnt;
    logic                            r_busy;
    logic [lddc_pkg::DIGIT_BITS:0]   w_sh;
    logic [lddc_pkg::DIGIT_BITS:0]   w_dif;

    assign w_sh  = {r_rem[lddc_pkg::DIGIT_BITS-1:0], r_q[VALUE_BITS-1]};
    assign w_dif = w_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_cnt  <= CW'(VALUE_BITS);
            end else if (r_busy) begin
                if (!w_dif[lddc_pkg::DIGIT_BITS]) begin
                    r_rem <= w_dif;
                    r_q   <= {r_q[VALUE_BITS-2:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_q   <= {r_q[VALUE_BITS-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quotient  = r_q;
    assign o_remainder = r_rem[lddc_pkg::DIGIT_BITS-1:0];
endmodule

[rtl/core/lucas_digit_dominance_count.sv]
// Top level of the digit dominance counter with its sequencer.
`timescale 1ns / 1ps
// Sequence: the limit and then the query are split into digits by the shared bit-serial
// divider, then a top-down scan and a bottom-up walk over the digits follow. One request
// at a time: busy stays high until the result strobe.
// Synchronous active-low reset clears control state; base returns to 2, limit to 0.
// The result is shown for one cycle on o_valid; the receiver cannot stall it.
module lucas_digit_dominance_count #(
    parameter int VALUE_BITS = lddc_pkg::VALUE_BITS,
    parameter int MAX_DIGITS = lddc_pkg::MAX_DIGITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [VALUE_BITS-1:0]             i_query,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lddc_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [63:0]                       i_cfg_data,
    output logic                              o_valid,
    output logic [VALUE_BITS-1:0]             o_excess_count,
    output logic [VALUE_BITS-1:0]             o_miss_rank,
    output logic [VALUE_BITS-1:0]             o_predecessor,
    output logic                              o_query_admissible
);
    localparam int DB = lddc_pkg::DIGIT_BITS;
    localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int LW = $clog2(MAX_DIGITS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_LDIV, S_LWAIT, S_QDIV, S_QWAIT, S_SCAN_RD, S_SCAN,
        S_ACC_RD, S_ACC_MUL, S_ACC_ADD, S_DONE
    } t_state;

    t_state                r_state;
    logic [DB-1:0]         r_base;
    logic [VALUE_BITS-1:0] r_limit;
    logic [DB-1:0]         r_p;
    logic [VALUE_BITS-1:0] r_n;
    logic [VALUE_BITS-1:0] r_val;
    logic [LW-1:0]         r_len;
    logic [LW-1:0]         r_qcnt;
    logic [LW-1:0]         r_idx;
    logic [LW-1:0]         r_h;
    logic                  r_found;
    logic [VALUE_BITS-1:0] r_w;
    logic [VALUE_BITS-1:0] r_place;
    logic [VALUE_BITS-1:0] r_pred;
    logic [VALUE_BITS-1:0] r_rank;
    logic [VALUE_BITS-1:0] r_prod_p;
    logic [VALUE_BITS-1:0] r_prod_w;

    // Divider
    logic                  w_div_start;
    logic                  w_div_done;
    logic [VALUE_BITS-1:0] w_quo;
    logic [DB-1:0]         w_rem;

    lddc_divider #(.VALUE_BITS(VALUE_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_dividend(r_val), .i_divisor(r_p), .o_done(w_div_done),
        .o_quotient(w_quo), .o_remainder(w_rem)
    );

    // Digit stores: limit digits and query digits.
    logic          w_lwe, w_qwe;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [DB-1:0] w_ld, w_qd, w_wdata;
    logic [DB-1:0] w_d;

    lddc_ram #(.WIDTH(DB), .DEPTH(MAX_DIGITS)) u_lram (
        .i_clk(i_clk), .i_we(w_lwe), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_ld)
    );
    lddc_ram #(.WIDTH(DB), .DEPTH(MAX_DIGITS)) u_qram (
        .i_clk(i_clk), .i_we(w_qwe), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_qd)
    );

    assign w_div_start = (r_state == S_LDIV) || (r_state == S_QDIV);
    assign w_wdata     = (r_state == S_QDIV) ? '0 : w_rem;
    // Writes happen as the divider finishes; the query store is also zero-filled.
    assign w_lwe   = (r_state == S_LWAIT) && w_div_done;
    assign w_qwe   = ((r_state == S_QWAIT) && w_div_done) || (r_state == S_QDIV);
    assign w_waddr = r_idx[AW-1:0];
    assign w_raddr = r_idx[AW-1:0];

    // Digit used by the predecessor: the query's above the top excess position (or at every
    // position if there is none), the limit's at and below it.
    assign w_d = (!r_found || r_idx > r_h) ? w_qd : w_ld;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);

    logic w_q_write_digit;
    assign w_q_write_digit = (r_val != '0) && (r_qcnt < r_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_base  <= lddc_pkg::BASE_RESET;
            r_limit <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    lddc_pkg::REG_BASE:  r_base  <= i_cfg_data[DB-1:0];
                    lddc_pkg::REG_LIMIT: r_limit <= i_cfg_data[VALUE_BITS-1:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_p   <= (r_base < DB'(2)) ? DB'(2) : r_base;
                        r_n   <= (i_query > r_limit) ? r_limit : i_query;
                        r_val <= r_limit;
                        r_idx <= '0;
                        r_len <= '0;
                        r_state <= S_LDIV;
                    end
                end
                // Split the limit into digits, at least one digit.
                S_LDIV: r_state <= S_LWAIT;
                S_LWAIT: begin
                    if (w_div_done) begin
                        r_val <= w_quo;
                        r_len <= r_idx + 1'b1;
                        if (w_quo == '0 || r_idx + 1'b1 == LW'(MAX_DIGITS)) begin
                            r_idx   <= '0;
                            r_val   <= r_n;
                            r_qcnt  <= '0;
                            r_state <= S_QDIV;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_LDIV;
                        end
                    end
                end
                // Query digits over the limit's length; zeros beyond its top.
                S_QDIV: r_state <= S_QWAIT;
                S_QWAIT: begin
                    if (w_div_done) begin
                        if (w_q_write_digit) begin
                            r_val  <= w_quo;
                            r_qcnt <= r_qcnt + 1'b1;
                        end
                        if (r_idx + 1'b1 == r_len) begin
                            r_idx   <= r_len - 1'b1;
                            r_found <= 1'b0;
                            r_h     <= r_len;
                            r_state <= S_SCAN_RD;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_QDIV;
                        end
                    end
                end
                // Top-down scan for the highest digit where query exceeds limit.
                S_SCAN_RD: r_state <= S_SCAN;
                S_SCAN: begin
                    if (w_qd > w_ld) begin
                        r_found <= 1'b1;
                        r_h     <= r_idx;
                    end
                    if (w_qd > w_ld || r_idx == '0) begin
                        r_idx   <= '0;
                        r_w     <= VALUE_BITS'(1);
                        r_place <= VALUE_BITS'(1);
                        r_pred  <= '0;
                        r_rank  <= '0;
                        r_state <= S_ACC_RD;
                    end else begin
                        r_idx   <= r_idx - 1'b1;
                        r_state <= S_SCAN_RD;
                    end
                end
                // Bottom-up walk: rank and predecessor accumulate.
                S_ACC_RD: r_state <= S_ACC_MUL;
                S_ACC_MUL: begin
                    r_prod_p <= r_place * VALUE_BITS'(w_d);
                    r_prod_w <= r_w * VALUE_BITS'(w_d);
                    r_state  <= S_ACC_ADD;
                end
                S_ACC_ADD: begin
                    r_pred  <= r_pred + r_prod_p;
                    r_rank  <= r_rank + r_prod_w;
                    r_place <= r_place * VALUE_BITS'(r_p);
                    r_w     <= r_w * (VALUE_BITS'(w_ld) + VALUE_BITS'(1));
                    if (r_idx + 1'b1 == r_len) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_ACC_RD;
                    end
                end
                S_DONE: begin
                    o_valid            <= 1'b1;
                    o_miss_rank        <= r_rank;
                    o_excess_count     <= r_n - r_rank;
                    o_predecessor      <= r_found ? r_pred : r_n;
                    o_query_admissible <= !r_found;
                    r_state            <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[tb/sv/lucas_digit_dominance_count_test.sv]
// Self-checking testbench for the digit dominance counter, with its own predictor.
`timescale 1ns / 1ps
module lucas_digit_dominance_count_test;

    localparam int CYCLE_LIMIT = 4000000;
    // Quiet cycles after the last result before a register write.
    localparam int SETTLE_CYCLES = 32;

    typedef enum logic {REQ_QUERY, REQ_CFG} t_req_kind;

    typedef struct {
        t_req_kind                         kind;
        logic [lddc_pkg::CFG_IDX_BITS-1:0] index;
        logic [63:0]                       data;
        int                                gap_pct;
    } t_request;

    typedef struct {
        logic [63:0] excess_count;
        logic [63:0] miss_rank;
        logic [63:0] predecessor;
        logic        query_admissible;
    } t_count_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [63:0] i_query = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [lddc_pkg::CFG_IDX_BITS-1:0] i_cfg_index = lddc_pkg::REG_BASE;
    logic [63:0] i_cfg_data = '0;
    logic        o_valid;
    logic [63:0] o_excess_count;
    logic [63:0] o_miss_rank;
    logic [63:0] o_predecessor;
    logic        o_query_admissible;

    // Shadow copy of the block's registers, updated at each accepted write.
    logic [15:0] shadow_base = lddc_pkg::BASE_RESET;
    logic [63:0] shadow_limit = '0;

    t_request      pending_reqs[$];
    t_count_result expected_counts[$];
    int            quiet_cycles = 0;
    int            cycle_count = 0;
    bit            failed = 1'b0;

    lucas_digit_dominance_count u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_query            (i_query),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_valid            (o_valid),
        .o_excess_count     (o_excess_count),
        .o_miss_rank        (o_miss_rank),
        .o_predecessor      (o_predecessor),
        .o_query_admissible (o_query_admissible)
    );

    always #2 i_clk = ~i_clk;

    // Computes the expected counts for one query under the given base and limit.
    // The clamped query and the limit are split into base-p digits, the top digit
    // where the query exceeds the limit is found, and the predecessor is ranked
    // with the mixed-radix weights prod(limit_j + 1).
    function automatic t_count_result count_dominance(logic [15:0] base_reg,
                                                      logic [63:0] limit_reg,
                                                      logic [63:0] query);
        logic [63:0]   lim_dig[lddc_pkg::MAX_DIGITS];
        logic [63:0]   qry_dig[lddc_pkg::MAX_DIGITS];
        logic [63:0]   weight[lddc_pkg::MAX_DIGITS];
        logic [63:0]   p, n, v, w, pred, rank, place, d;
        int            len, cnt, h;
        bit            adm;
        t_count_result r;
        p = (base_reg < 2) ? 64'd2 : {48'd0, base_reg};
        n = (query > limit_reg) ? limit_reg : query;
        for (int i = 0; i < lddc_pkg::MAX_DIGITS; i++) begin
            lim_dig[i] = '0;
            qry_dig[i] = '0;
            weight[i] = '0;
        end
        len = 0;
        v = limit_reg;
        while (v > 0 && len < lddc_pkg::MAX_DIGITS) begin
            lim_dig[len] = v % p;
            v = v / p;
            len++;
        end
        if (len == 0)
            len = 1;
        cnt = 0;
        v = n;
        while (v > 0 && cnt < lddc_pkg::MAX_DIGITS) begin
            qry_dig[cnt] = v % p;
            v = v / p;
            cnt++;
        end
        w = 64'd1;
        for (int i = 0; i < len; i++) begin
            weight[i] = w;
            w = w * (lim_dig[i] + 64'd1);
        end
        h = len;
        for (int i = len; i > 0; i--) begin
            if (qry_dig[i-1] > lim_dig[i-1]) begin
                h = i - 1;
                break;
            end
        end
        adm = (h == len);
        pred = '0;
        rank = '0;
        place = 64'd1;
        for (int i = 0; i < len; i++) begin
            d = (adm || i > h) ? qry_dig[i] : lim_dig[i];
            pred = pred + d * place;
            rank = rank + d * weight[i];
            place = place * p;
        end
        if (adm)
            pred = n;
        r.excess_count = n - rank;
        r.miss_rank = rank;
        r.predecessor = pred;
        r.query_admissible = adm;
        return r;
    endfunction

    function automatic void add_query(logic [63:0] q, int gap_pct);
        t_request r;
        r.kind = REQ_QUERY;
        r.index = lddc_pkg::REG_BASE;
        r.data = q;
        r.gap_pct = gap_pct;
        pending_reqs.insert(pending_reqs.size(), r);
    endfunction

    function automatic void add_write(logic [lddc_pkg::CFG_IDX_BITS-1:0] idx,
                                      logic [63:0] val);
        t_request r;
        r.kind = REQ_CFG;
        r.index = idx;
        r.data = val;
        r.gap_pct = 0;
        pending_reqs.insert(pending_reqs.size(), r);
    endfunction

    // A random value of random bit length, so that small values turn up often.
    function automatic logic [63:0] rand_value(int max_bits);
        logic [63:0] v;
        int          nbits;
        v = {$urandom, $urandom};
        nbits = $urandom_range(max_bits, 1);
        return (nbits >= 64) ? v : (v & ((64'd1 << nbits) - 64'd1));
    endfunction

    // Fill the request queue: a directed part first, then random groups, each
    // group opening with a fresh base and limit.
    initial begin
        logic [63:0] lim;
        int          gap;
        int          pick;
        // Reset defaults: base 2, zero limit, so every query clamps to zero.
        add_query(64'd0, 0);
        add_query({64{1'b1}}, 0);
        add_query(64'h5555_5555_5555_5555, 0);
        // Base zero and base one behave as base two.
        add_write(lddc_pkg::REG_BASE, 64'd0);
        add_write(lddc_pkg::REG_LIMIT, 64'd10);
        add_query(64'd5, 0);
        add_query(64'd7, 0);
        add_write(lddc_pkg::REG_BASE, 64'd1);
        add_query(64'd6, 0);
        add_query(64'd10, 0);
        // Base three, query above the limit (clamped), admissible and not.
        add_write(lddc_pkg::REG_BASE, 64'd3);
        add_write(lddc_pkg::REG_LIMIT, 64'd100);
        add_query(64'd100, 0);
        add_query(64'd1000, 0);
        add_query(64'd53, 0);
        add_query(64'd26, 0);
        // Largest base; upper data bits of the write are dropped by the register.
        add_write(lddc_pkg::REG_BASE, 64'hFFFF_0000_0000_FFFF);
        add_write(lddc_pkg::REG_LIMIT, {64{1'b1}});
        add_query({64{1'b1}}, 0);
        add_query(64'd65535, 0);
        add_query(64'hAAAA_AAAA_AAAA_AAAA, 0);
        // Full-width limit in base two: the slowest case, the limit has 64 digits.
        add_write(lddc_pkg::REG_BASE, 64'd2);
        add_query({64{1'b1}}, 0);
        add_query(64'h8000_0000_0000_0000, 0);
        add_write(lddc_pkg::REG_LIMIT, 64'h8000_0000_0000_0000);
        add_query(64'h7FFF_FFFF_FFFF_FFFF, 0);
        add_query(64'h0123_4567_89AB_CDEF, 0);
        // Random part: sender gaps of 27 percent, then 52 percent, then none.
        for (int g = 0; g < 12; g++) begin
            gap = (g < 4) ? 27 : (g < 8) ? 52 : 0;
            pick = $urandom_range(5, 0);
            case (pick)
                0: add_write(lddc_pkg::REG_BASE, 64'd2);
                1: add_write(lddc_pkg::REG_BASE, 64'd3);
                2: add_write(lddc_pkg::REG_BASE, 64'd7);
                3: add_write(lddc_pkg::REG_BASE, 64'd65535);
                4: add_write(lddc_pkg::REG_BASE, {$urandom, $urandom});
                default: add_write(lddc_pkg::REG_BASE, 64'($urandom_range(65535, 0)));
            endcase
            // Mostly short limits keep the digit splits fast; a few are full width.
            lim = ($urandom_range(9, 0) == 0) ? {$urandom, $urandom} : rand_value(24);
            add_write(lddc_pkg::REG_LIMIT, lim);
            for (int k = 0; k < 7; k++) begin
                pick = $urandom_range(3, 0);
                case (pick)
                    0: add_query({$urandom, $urandom}, gap);
                    1: add_query(lim, gap);
                    default: add_query(rand_value(25), gap);
                endcase
            end
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Driver: issues requests from the queue. Register writes wait until no
    // result is outstanding and the block has been quiet for a while.
    always @(posedge i_clk) begin
        if (o_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_counts.insert(expected_counts.size(),
                                       count_dominance(shadow_base, shadow_limit, i_query));
                void'(pending_reqs.pop_front());
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == lddc_pkg::REG_BASE)
                    shadow_base <= i_cfg_data[15:0];
                else
                    shadow_limit <= i_cfg_data;
                void'(pending_reqs.pop_front());
            end
            // An unaccepted request stays on the ports.
            if (!((start && busy) || (i_cfg_valid && !o_cfg_ready))) begin
                if (pending_reqs.size() > 0 && pending_reqs[0].kind == REQ_QUERY
                    && $urandom_range(99, 0) >= pending_reqs[0].gap_pct) begin
                    start <= 1'b1;
                    i_cfg_valid <= 1'b0;
                    i_query <= pending_reqs[0].data;
                end else if (pending_reqs.size() > 0 && pending_reqs[0].kind == REQ_CFG
                             && expected_counts.size() == 0 && !busy && !start
                             && !i_cfg_valid && quiet_cycles >= SETTLE_CYCLES) begin
                    start <= 1'b0;
                    i_cfg_valid <= 1'b1;
                    i_cfg_index <= pending_reqs[0].index;
                    i_cfg_data <= pending_reqs[0].data;
                end else begin
                    start <= 1'b0;
                    i_cfg_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed result is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_count_result exp_r;
        if (i_rst_n && o_valid) begin
            if (expected_counts.size() == 0) begin
                $error("unexpected result: excess_count %0d", o_excess_count);
                failed = 1'b1;
            end else begin
                exp_r = expected_counts.pop_front();
                if (o_excess_count !== exp_r.excess_count) begin
                    $error("excess_count: expected %0d, actual %0d",
                           exp_r.excess_count, o_excess_count);
                    failed = 1'b1;
                end
                if (o_miss_rank !== exp_r.miss_rank) begin
                    $error("miss_rank: expected %0d, actual %0d", exp_r.miss_rank, o_miss_rank);
                    failed = 1'b1;
                end
                if (o_predecessor !== exp_r.predecessor) begin
                    $error("predecessor: expected %0d, actual %0d",
                           exp_r.predecessor, o_predecessor);
                    failed = 1'b1;
                end
                if (o_query_admissible !== exp_r.query_admissible) begin
                    $error("query_admissible: expected %0d, actual %0d",
                           exp_r.query_admissible, o_query_admissible);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // End of run: all requests issued, all results in, then a settling pause.
    initial begin
        wait (i_rst_n);
        wait (pending_reqs.size() == 0 && expected_counts.size() == 0);
        repeat (200) @(posedge i_clk);
        if (expected_counts.size() != 0)
            failed = 1'b1;
        if (!failed)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

[filelist.f]
rtl/core/lddc_pkg.sv
rtl/core/lddc_ram.sv
rtl/core/lddc_divider.sv
rtl/core/lucas_digit_dominance_count.sv
tb/sv/lucas_digit_dominance_count_test.sv
